### rtl/bmmd_pkg.sv
package bmmd_pkg;

  localparam int VIDEO_BANKS = 2;
  localparam int WORK_BANKS  = 8;

  localparam int VBANK_SIZE = 'h2000;
  localparam int WBANK_SIZE = 'h1000;

  // Unified RAM layout: work banks, video banks, then the small stores
  localparam int WORK_BASE   = 0;
  localparam int VIDEO_BASE  = WORK_BASE + WORK_BANKS * WBANK_SIZE;
  localparam int MISC_BASE   = VIDEO_BASE + VIDEO_BANKS * VBANK_SIZE;
  localparam int SPRITE_BASE = MISC_BASE;
  localparam int HIGH_BASE   = MISC_BASE + 'h100;
  localparam int BGPAL_BASE  = MISC_BASE + 'h200;
  localparam int SPPAL_BASE  = MISC_BASE + 'h240;
  localparam int IO_BASE     = MISC_BASE + 'h280;
  localparam int MEM_DEPTH   = MISC_BASE + 'h300;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // IO byte offsets within FF00-FF7F
  localparam logic [6:0] IO_VBANK    = 7'h4F;
  localparam logic [6:0] IO_BG_INDEX = 7'h68;
  localparam logic [6:0] IO_BG_DATA  = 7'h69;
  localparam logic [6:0] IO_SP_INDEX = 7'h6A;
  localparam logic [6:0] IO_SP_DATA  = 7'h6B;
  localparam logic [6:0] IO_WBANK    = 7'h70;

  localparam logic [7:0] WBANK_RESET = 8'h01;
  localparam logic [7:0] PAL_AUTOINC = 8'h80;
  localparam logic [5:0] PAL_IDX_ONE = 6'd1;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       cart_access;
  } rsp_t;

  // Switchable work bank: 0 selects 1, then wrap to the banks present
  function automatic logic [2:0] work_bank_of(input logic [2:0] raw);
    logic [2:0] sel;
    logic [2:0] r;
    sel = (raw == 3'd0) ? 3'd1 : raw;
    r   = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (sel == 3'(k)) r = 3'(k % WORK_BANKS);
    end
    return r;
  endfunction

endpackage

### rtl/banked_memory_map_decoder_core.sv
// Memory map decoder for a 16-bit bus with banked video and work RAM. It takes one
// request (read or write) per cycle unless the output stalls; each response passes
// s1, then rsp. A stalled response holds back at most one more request.
// Video RAM, work RAM, sprite RAM, high RAM, both palette stores and the plain IO
// bytes share one single-port synchronous RAM; the single read per cycle of that
// RAM sets the one-request-per-cycle rate. Bank selects (FF4F, FF70), the palette
// index bytes (FF68, FF6A) and the interrupt-enable byte live in flops, so a
// request sees bank changes made by the request just before it. Plain IO bytes
// read zero until written. Cartridge ranges return zero and raise cart_access. No
// clearing pass is run after reset.
module banked_memory_map_decoder_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bmmd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bmmd_pkg::rsp_t rsp
);

  logic [7:0] mem [bmmd_pkg::MEM_DEPTH];
  logic [7:0] mem_q;

  logic [7:0]   vbank_reg, wbank_reg, bg_index, sp_index, ie_reg;
  logic [7:0]   vbank_next, wbank_next, bg_index_next, sp_index_next, ie_next;
  logic [127:0] io_valid;

  logic         s1_valid, s1_use_mem, s1_cart;
  logic [7:0]   s1_direct;

  logic                      accept, out_adv, is_write;
  logic                      mem_en, use_mem, cart, io_set;
  logic [bmmd_pkg::MEM_AW-1:0] mem_addr;
  logic [7:0]                direct;
  logic [6:0]                io_off;
  logic                      vbank_sel;
  logic [2:0]                wbank_sel;

  assign out_adv   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || out_adv;
  assign accept    = req_valid && req_ready;
  assign is_write  = req.action == bmmd_pkg::ACT_WRITE;
  assign io_off    = req.address[6:0];
  assign vbank_sel = (bmmd_pkg::VIDEO_BANKS > 1) ? vbank_reg[0] : 1'b0;

  always_comb begin
    mem_en        = 1'b0;
    mem_addr      = '0;
    direct        = 8'h00;
    cart          = 1'b0;
    io_set        = 1'b0;
    wbank_sel     = 3'd0;
    vbank_next    = vbank_reg;
    wbank_next    = wbank_reg;
    bg_index_next = bg_index;
    sp_index_next = sp_index;
    ie_next       = ie_reg;
    priority if (!req.address[15] || req.address[15:13] == 3'b101) begin
      cart = 1'b1;
    end else if (req.address[15:13] == 3'b100) begin
      mem_en   = 1'b1;
      mem_addr = bmmd_pkg::MEM_AW'(bmmd_pkg::VIDEO_BASE)
               + bmmd_pkg::MEM_AW'({vbank_sel, req.address[12:0]});
    end else if (req.address < 16'hFE00) begin
      // Work RAM and its echo: bit 12 picks the switchable half
      wbank_sel = req.address[12] ? bmmd_pkg::work_bank_of(wbank_reg[2:0]) : 3'd0;
      mem_en    = 1'b1;
      mem_addr  = bmmd_pkg::MEM_AW'(bmmd_pkg::WORK_BASE)
                + bmmd_pkg::MEM_AW'({wbank_sel, req.address[11:0]});
    end else if (req.address < 16'hFEA0) begin
      mem_en   = 1'b1;
      mem_addr = bmmd_pkg::MEM_AW'(bmmd_pkg::SPRITE_BASE)
               + bmmd_pkg::MEM_AW'(req.address[7:0]);
    end else if (req.address < 16'hFF00) begin
      direct = 8'h00;
    end else if (req.address < 16'hFF80) begin
      priority if (io_off == bmmd_pkg::IO_BG_DATA) begin
        mem_en   = 1'b1;
        mem_addr = bmmd_pkg::MEM_AW'(bmmd_pkg::BGPAL_BASE)
                 + bmmd_pkg::MEM_AW'(bg_index[5:0]);
        if (is_write && bg_index[7]) begin
          bg_index_next = bmmd_pkg::PAL_AUTOINC
                        | {2'b00, bg_index[5:0] + bmmd_pkg::PAL_IDX_ONE};
        end
      end else if (io_off == bmmd_pkg::IO_SP_DATA) begin
        mem_en   = 1'b1;
        mem_addr = bmmd_pkg::MEM_AW'(bmmd_pkg::SPPAL_BASE)
                 + bmmd_pkg::MEM_AW'(sp_index[5:0]);
        if (is_write && sp_index[7]) begin
          sp_index_next = bmmd_pkg::PAL_AUTOINC
                        | {2'b00, sp_index[5:0] + bmmd_pkg::PAL_IDX_ONE};
        end
      end else if (io_off == bmmd_pkg::IO_VBANK) begin
        direct = vbank_reg;
        if (is_write) vbank_next = req.write_data;
      end else if (io_off == bmmd_pkg::IO_WBANK) begin
        direct = wbank_reg;
        if (is_write) wbank_next = req.write_data;
      end else if (io_off == bmmd_pkg::IO_BG_INDEX) begin
        direct = bg_index;
        if (is_write) bg_index_next = req.write_data;
      end else if (io_off == bmmd_pkg::IO_SP_INDEX) begin
        direct = sp_index;
        if (is_write) sp_index_next = req.write_data;
      end else begin
        // Plain IO byte: unwritten bytes read their reset value of zero
        mem_en   = is_write || io_valid[io_off];
        io_set   = is_write;
        mem_addr = bmmd_pkg::MEM_AW'(bmmd_pkg::IO_BASE) + bmmd_pkg::MEM_AW'(io_off);
      end
    end else if (req.address != 16'hFFFF) begin
      mem_en   = 1'b1;
      mem_addr = bmmd_pkg::MEM_AW'(bmmd_pkg::HIGH_BASE)
               + bmmd_pkg::MEM_AW'(req.address[6:0]);
    end else begin
      direct = ie_reg;
      if (is_write) ie_next = req.write_data;
    end
    if (is_write) direct = 8'h00;
    use_mem = mem_en && !is_write;
  end

  always_ff @(posedge clk) begin
    if (accept && mem_en) begin
      if (is_write) begin
        mem[mem_addr] <= req.write_data;
      end else begin
        mem_q <= mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbank_reg <= 8'h00;
      wbank_reg <= bmmd_pkg::WBANK_RESET;
      bg_index  <= 8'h00;
      sp_index  <= 8'h00;
      ie_reg    <= 8'h00;
      io_valid  <= '0;
    end else if (accept) begin
      vbank_reg <= vbank_next;
      wbank_reg <= wbank_next;
      bg_index  <= bg_index_next;
      sp_index  <= sp_index_next;
      ie_reg    <= ie_next;
      if (io_set) io_valid[io_off] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) s1_valid <= req_valid;
      if (out_adv) rsp_valid <= s1_valid;
    end
  end

  // Hold the RAM read in mem_q until the stage ahead frees up
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_mem <= use_mem;
      s1_direct  <= direct;
      s1_cart    <= cart;
    end
    if (out_adv && s1_valid) begin
      rsp.read_data   <= s1_use_mem ? mem_q : s1_direct;
      rsp.cart_access <= s1_cart;
    end
  end

endmodule

### rtl/bmmd_checker.sv
module bmmd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input bmmd_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input bmmd_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_cart_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.cart_access |-> rsp.read_data == 8'h00)
    else $error("cartridge response carries data");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid && req_ready)
    else $error("pipeline not empty after reset");

endmodule

bind banked_memory_map_decoder_core bmmd_checker u_bmmd_checker (.*);
